FILE: rtl/tcpa_pkg.sv
package tcpa_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CAPACITY_RESET = 8'd2;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_EXIT    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_ADMITTED = 2'd1,
      STATUS_REJECTED = 2'd2,
      STATUS_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic       command;
      logic       is_priority;
      logic [7:0] client_id;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] admitted_id;
      logic       admitted_priority;
      logic [7:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

FILE: rtl/two_class_priority_admission_top.sv
// Admission controller for a resource that holds at most "capacity" clients,
// with a priority and a normal class. Each request transfer is an arrival
// (command 0) or an exit (command 1) and yields exactly one response transfer:
// status, the admitted client's id and class (zero unless status is admitted),
// and the occupancy after the event. Arrivals that find no room or find anyone
// waiting join their class FIFO; a full FIFO rejects. An exit hands its place
// to the oldest priority client first, then the oldest normal client. One
// request is taken per clock cycle while the response side is not stalled;
// the input register captures the request, then the response register takes
// the result of one pass of compare/count logic once the response slot is
// free. Write capacity through the csr port only while no request is in
// flight; it is always ready.
module two_class_priority_admission_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcpa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import tcpa_pkg::*;

   // configuration
   logic [7:0] capacity_ff;

   // input register
   logic    in_valid_ff;
   req_type in_item_ff;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // admitted count
   logic [7:0] occupied_ff, occupied_in;

   // queue controls
   logic             advance;
   logic             prio_push, prio_pop, norm_push, norm_pop;
   logic [7:0]       prio_head_id, norm_head_id;
   queue_status_type prio_status, norm_status;
   logic [7:0]       occupied_dec;

   assign csr_ready = 1'b1;

   // the pass fires when an item is staged and the response slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // one event: arrival admits, queues or rejects; exit frees and refills
   always_comb begin
      prio_push    = 1'b0;
      prio_pop     = 1'b0;
      norm_push    = 1'b0;
      norm_pop     = 1'b0;
      occupied_in  = occupied_ff;
      occupied_dec = occupied_ff - 1'b1;
      rsp_in       = '0;
      rsp_in.status = STATUS_NONE;

      if (in_item_ff.command == CMD_ARRIVAL) begin
         if ((occupied_ff < capacity_ff) && prio_status.empty && norm_status.empty) begin
            occupied_in              = occupied_ff + 1'b1;
            rsp_in.status            = STATUS_ADMITTED;
            rsp_in.admitted_id       = in_item_ff.client_id;
            rsp_in.admitted_priority = in_item_ff.is_priority;
         end else if (in_item_ff.is_priority) begin
            if (prio_status.full) begin
               rsp_in.status = STATUS_REJECTED;
            end else begin
               prio_push = 1'b1;
            end
         end else begin
            if (norm_status.full) begin
               rsp_in.status = STATUS_REJECTED;
            end else begin
               norm_push = 1'b1;
            end
         end
      end else begin
         if (occupied_ff == '0) begin
            rsp_in.status = STATUS_IGNORED;
         end else if ((occupied_dec < capacity_ff) && !prio_status.empty) begin
            // place handed over: count stays the same
            prio_pop                 = 1'b1;
            rsp_in.status            = STATUS_ADMITTED;
            rsp_in.admitted_id       = prio_head_id;
            rsp_in.admitted_priority = 1'b1;
         end else if ((occupied_dec < capacity_ff) && !norm_status.empty) begin
            norm_pop                 = 1'b1;
            rsp_in.status            = STATUS_ADMITTED;
            rsp_in.admitted_id       = norm_head_id;
            rsp_in.admitted_priority = 1'b0;
         end else begin
            occupied_in = occupied_dec;
         end
      end
      rsp_in.occupancy = occupied_in;
   end

   tcpa_queue u_prio_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (advance && prio_push),
      .push_id (in_item_ff.client_id),
      .pop     (advance && prio_pop),
      .head_id (prio_head_id),
      .status  (prio_status)
   );

   tcpa_queue u_norm_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (advance && norm_push),
      .push_id (in_item_ff.client_id),
      .pop     (advance && norm_pop),
      .head_id (norm_head_id),
      .status  (norm_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            occupied_ff <= occupied_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/tcpa_queue.sv
module tcpa_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [7:0]                 push_id,
   input  logic                       pop,
   output logic [7:0]                 head_id,
   output tcpa_pkg::queue_status_type status
);
   import tcpa_pkg::*;

   logic [7:0]       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W:0]   tail_sum;
   logic [CNT_W:0]   tail_wrap;
   logic [PTR_W-1:0] tail;

   // tail = (head + count) mod depth; sum stays below twice the depth
   always_comb begin
      tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         tail_wrap = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end else begin
         tail_wrap = tail_sum;
      end
      tail = tail_wrap[PTR_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         if (head_ff == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail] <= push_id;
      end
   end

   assign head_id      = entry_ff[head_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/tcpa_checker.sv
module tcpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcpa_pkg::rsp_type rsp_data
);
   import tcpa_pkg::*;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no response out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // admitted fields are zero unless someone is admitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_ADMITTED) |->
         (rsp_data.admitted_id == 8'd0) && !rsp_data.admitted_priority)
      else $error("admitted fields set without admission");

   // an admission leaves at least one client in
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ADMITTED) |-> rsp_data.occupancy != 8'd0)
      else $error("admission with zero occupancy");

   // an ignored exit only happens when nobody is in
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_IGNORED) |-> rsp_data.occupancy == 8'd0)
      else $error("exit ignored with clients admitted");

endmodule

bind two_class_priority_admission_top tcpa_checker u_tcpa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
